// File: sv/base64_stream_encoder_defines.svh
// Assertion helpers, clocked on clk_i, disabled during reset.
`ifndef BASE64_STREAM_ENCODER_DEFINES_SVH
`define BASE64_STREAM_ENCODER_DEFINES_SVH

// Same-cycle implication.
`define B64_ASSERT_IMP(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define B64_ASSERT_NXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/b64_pkg.sv
`timescale 1ns / 1ps
package b64_pkg;

  localparam logic [6:0] PadChar    = 7'd61;
  localparam logic [6:0] CharUpperA = 7'd65;
  localparam logic [6:0] CharLowerA = 7'd97;
  localparam logic [6:0] CharZero   = 7'd48;
  localparam logic [6:0] CharPlus   = 7'd43;
  localparam logic [6:0] CharSlash  = 7'd47;

  // One complete or padded group, as handed from front to back.
  typedef struct packed {
    logic [23:0] triple;
    logic [1:0]  pads;
    logic        last;
  } group_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef struct packed {
    logic [1:0] phase;
  } front_stat_t;

  function automatic logic [6:0] b64_char(input logic [5:0] v);
    logic [6:0] c;
    priority if (v < 6'd26) begin
      c = CharUpperA + {1'b0, v};
    end else if (v < 6'd52) begin
      c = CharLowerA + {1'b0, v} - 7'd26;
    end else if (v < 6'd62) begin
      c = CharZero + {1'b0, v} - 7'd52;
    end else if (v == 6'd62) begin
      c = CharPlus;
    end else begin
      c = CharSlash;
    end
    return c;
  endfunction

endpackage

// File: sv/b64_front.sv
`timescale 1ns / 1ps
module b64_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 final_byte_i,
  output logic                 full_o,
  input  b64_pkg::queue_stat_t q_stat_i,
  output logic                 q_push_o,
  output b64_pkg::group_t      q_data_o,
  output b64_pkg::front_stat_t stat_o
);
  import b64_pkg::*;

  logic [1:0]  phase_q, phase_d;
  logic [15:0] pend_q, pend_d;
  logic [1:0]  phase;
  logic        xfer;

  assign full_o = q_stat_i.full;
  assign xfer   = push_i && !q_stat_i.full;
  assign phase  = (phase_q == 2'd3) ? 2'd0 : phase_q;

  always_comb begin
    phase_d  = phase_q;
    pend_d   = pend_q;
    q_push_o = 1'b0;
    q_data_o = '0;
    if (xfer) begin
      unique case (phase)
        2'd2: begin
          q_push_o = 1'b1;
          q_data_o = '{triple: {pend_q, data_byte_i}, pads: 2'd0, last: final_byte_i};
          phase_d  = 2'd0;
          pend_d   = '0;
        end
        2'd1: begin
          if (final_byte_i) begin
            q_push_o = 1'b1;
            q_data_o = '{triple: {pend_q[15:8], data_byte_i, 8'd0}, pads: 2'd1, last: 1'b1};
            phase_d  = 2'd0;
            pend_d   = '0;
          end else begin
            phase_d = 2'd2;
            pend_d  = {pend_q[15:8], data_byte_i};
          end
        end
        default: begin
          if (final_byte_i) begin
            q_push_o = 1'b1;
            q_data_o = '{triple: {data_byte_i, 16'd0}, pads: 2'd2, last: 1'b1};
            phase_d  = 2'd0;
            pend_d   = '0;
          end else begin
            phase_d = 2'd1;
            pend_d  = {data_byte_i, 8'd0};
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
      pend_q  <= '0;
    end else begin
      phase_q <= phase_d;
      pend_q  <= pend_d;
    end
  end

  assign stat_o.phase = phase_q;

endmodule

// File: sv/b64_queue.sv
`timescale 1ns / 1ps
module b64_queue #(
  parameter int Depth = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  b64_pkg::group_t      wdata_i,
  input  logic                 pop_i,
  output b64_pkg::group_t      rdata_o,
  output b64_pkg::queue_stat_t stat_o
);
  import b64_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  group_t          mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign stat_o.full  = (cnt_q == DepthCnt);
  assign stat_o.empty = (cnt_q == '0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// File: sv/b64_back.sv
`timescale 1ns / 1ps
module b64_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  b64_pkg::queue_stat_t q_stat_i,
  input  b64_pkg::group_t      q_data_i,
  output logic                 q_pop_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output logic [6:0]           code_char_o,
  output logic                 end_of_text_o
);
  import b64_pkg::*;

  group_t     grp_q, grp_d;
  logic [1:0] idx_q, idx_d;
  logic       busy_q, busy_d;
  logic       xfer, done;
  logic [5:0] sextet;
  logic [2:0] pad_sum;

  assign xfer    = pop_i && busy_q;
  assign done    = !busy_q || (xfer && idx_q == 2'd3);
  assign q_pop_o = done && !q_stat_i.empty;

  always_comb begin
    grp_d  = grp_q;
    idx_d  = idx_q;
    busy_d = busy_q;
    if (xfer) begin
      idx_d = idx_q + 1'b1;
    end
    if (done) begin
      busy_d = !q_stat_i.empty;
      idx_d  = 2'd0;
      if (!q_stat_i.empty) begin
        grp_d = q_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= 2'd0;
      busy_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  always_comb begin
    unique case (idx_q)
      2'd0: sextet = grp_q.triple[23:18];
      2'd1: sextet = grp_q.triple[17:12];
      2'd2: sextet = grp_q.triple[11:6];
      default: sextet = grp_q.triple[5:0];
    endcase
  end

  // pad when idx >= 4 - pads
  assign pad_sum       = {1'b0, idx_q} + {1'b0, grp_q.pads};
  assign code_char_o   = pad_sum[2] ? PadChar : b64_char(sextet);
  assign end_of_text_o = grp_q.last && (idx_q == 2'd3);
  assign empty_o       = !busy_q;

endmodule

// File: sv/base64_stream_encoder.sv
`timescale 1ns / 1ps
// Channel   Handshake           Payload
// input     push_i / full_o     data_byte_i[7:0], final_byte_i
// result    pop_i / empty_o     code_char_o[6:0], end_of_text_o
//
// One byte is taken per cycle while the group queue has room; a group of four
// characters leaves at one character per cycle while pop_i is high, so sustained
// rate is four characters per three bytes, set by the single character output port.
// Reset clears group phase, queue pointers and the character sequencer.
// A stalled result side fills the FifoDepth-entry queue, then raises full_o.
module base64_stream_encoder #(
  parameter int FifoDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [7:0] data_byte_i,
  input  logic       final_byte_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [6:0] code_char_o,
  output logic       end_of_text_o
);
  import b64_pkg::*;
  `include "base64_stream_encoder_defines.svh"

  queue_stat_t q_stat;
  front_stat_t f_stat;
  group_t      q_wdata, q_rdata;
  logic        q_push, q_pop;

  b64_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .full_o       (full_o),
    .q_stat_i     (q_stat),
    .q_push_o     (q_push),
    .q_data_o     (q_wdata),
    .stat_o       (f_stat)
  );

  b64_queue #(
    .Depth (FifoDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .stat_o  (q_stat)
  );

  b64_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_stat_i      (q_stat),
    .q_data_i      (q_rdata),
    .q_pop_o       (q_pop),
    .pop_i         (pop_i),
    .empty_o       (empty_o),
    .code_char_o   (code_char_o),
    .end_of_text_o (end_of_text_o)
  );

  `B64_ASSERT_IMP(a_no_push_full, q_push, !q_stat.full, "group pushed into full queue")
  `B64_ASSERT_IMP(a_no_pop_empty, q_pop, !q_stat.empty, "group popped from empty queue")
  `B64_ASSERT_NXT(a_final_clears, push_i && !full_o && final_byte_i, f_stat.phase == 2'd0,
                  "group phase not cleared after final byte")
  `B64_ASSERT_IMP(a_char_range, !empty_o, code_char_o >= 7'd43 && code_char_o <= 7'd122,
                  "character outside alphabet")

endmodule
